>>> src/psd_pkg.sv
// Shared widths and types for the polygon signed distance block.
package psd_pkg;
   localparam int COORD_BITS = 16;
   localparam int MAX_VERTICES = 256;
   localparam int VTX_AW = $clog2(MAX_VERTICES);
   localparam int CNT_BITS = VTX_AW + 1;
   localparam int DIST_BITS = 18;
   localparam int SQ_BITS = 36;
   localparam int ROOT_BITS = SQ_BITS / 2;
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [CNT_BITS-1:0] vertex_count;
      logic signed_mode;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } vertex_type;
endpackage

>>> src/psd_vertex_ram.sv
// Vertex table memory with one write port and one registered read port.
module psd_vertex_ram import psd_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [VTX_AW-1:0] wr_addr,
   input  vertex_type        wr_data,
   input  logic [VTX_AW-1:0] rd_addr,
   output vertex_type        rd_data
);
   vertex_type mem [MAX_VERTICES];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

>>> src/psd_csr.sv
// Configuration registers behind the APB-style port.
module psd_csr import psd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);
   localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;
   localparam logic [2:0] ADDR_SIGNED_MODE = 3'd4;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr;

   assign wr = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      unique case (paddr)
         ADDR_VERTEX_COUNT: begin
            prdata = {{(32-CNT_BITS){1'b0}}, cfg_ff.vertex_count};
            if (wr) begin
               cfg_in.vertex_count = pwdata[CNT_BITS-1:0];
            end
         end
         ADDR_SIGNED_MODE: begin
            prdata = {31'd0, cfg_ff.signed_mode};
            if (wr) begin
               cfg_in.signed_mode = pwdata[0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_count <= CNT_BITS'(3);
         cfg_ff.signed_mode <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg = cfg_ff;
endmodule

>>> src/psd_sqrt.sv
// Iterative rounded square root, one result bit per cycle, saturated magnitude.
module psd_sqrt import psd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SQ_BITS-1:0]   value,
   output logic                 done,
   output logic [DIST_BITS-2:0] mag
);
   localparam logic [ROOT_BITS:0] MAG_MAX = (ROOT_BITS+1)'((1 << (DIST_BITS-1)) - 1);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [4:0]           k_ff, k_in;
   logic [SQ_BITS-1:0]   x_ff, x_in;
   logic [SQ_BITS-1:0]   r_ff, r_in;
   logic [SQ_BITS-1:0]   bitv;
   logic [SQ_BITS:0]     trial;
   logic [ROOT_BITS:0]   rounded;

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      k_in = k_ff;
      x_in = x_ff;
      r_in = r_ff;
      bitv = SQ_BITS'(1) << {k_ff, 1'b0};
      trial = {1'b0, r_ff} + {1'b0, bitv};
      rounded = (x_ff > r_ff) ? (ROOT_BITS+1)'(r_ff) + 1'b1 : (ROOT_BITS+1)'(r_ff);
      if (start) begin
         run_in = 1'b1;
         k_in = 5'(ROOT_BITS - 1);
         x_in = value;
         r_in = '0;
      end else if (run_ff) begin
         if ({1'b0, x_ff} >= trial) begin
            x_in = x_ff - trial[SQ_BITS-1:0];
            r_in = (r_ff >> 1) + bitv;
         end else begin
            r_in = r_ff >> 1;
         end
         if (k_ff == 5'd0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      k_ff <= k_in;
      x_ff <= x_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign mag = (rounded > MAG_MAX) ? MAG_MAX[DIST_BITS-2:0] : rounded[DIST_BITS-2:0];
endmodule

>>> src/psd_edge_engine.sv
// Edge walker: reads vertices, finds segment distances and the crossing parity.
module psd_edge_engine import psd_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        opcode,
   input  logic [VTX_AW-1:0]           vertex_index,
   input  logic signed [COORD_BITS-1:0] x_coord,
   input  logic signed [COORD_BITS-1:0] y_coord,
   input  cfg_type                     cfg,
   output logic                        wr_en,
   output logic [VTX_AW-1:0]           wr_addr,
   output vertex_type                  wr_data,
   output logic [VTX_AW-1:0]           rd_addr,
   input  vertex_type                  rd_data,
   output logic                        sqrt_start,
   output logic [SQ_BITS-1:0]          sqrt_value,
   input  logic                        sqrt_done,
   input  logic [DIST_BITS-2:0]        sqrt_mag,
   output logic                        rsp_valid,
   output logic signed [DIST_BITS-1:0] rsp_distance,
   output logic                        rsp_inside_res
);
   localparam int EW = COORD_BITS + 1;
   localparam int PW = 2 * EW;
   localparam int BW = EW + 2;
   localparam int QW = 2 * BW;
   localparam int DW = PW + 2;
   localparam int EEW = PW + 1;
   localparam int HW = 16;

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b000000000001,
      ST_RDLAST = 12'b000000000010,
      ST_LDLAST = 12'b000000000100,
      ST_LOAD   = 12'b000000001000,
      ST_MUL    = 12'b000000010000,
      ST_SUM    = 12'b000000100000,
      ST_DIV    = 12'b000001000000,
      ST_SCALE  = 12'b000010000000,
      ST_BSUB   = 12'b000100000000,
      ST_SQ     = 12'b001000000000,
      ST_ACC    = 12'b010000000000,
      ST_ROOT   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_BITS-1:0] prevx_ff, prevx_in, prevy_ff, prevy_in;
   logic signed [COORD_BITS-1:0] curx_ff, curx_in, cury_ff, cury_in;
   logic [VTX_AW-1:0] last_ff, last_in, idx_ff, idx_in;
   logic sm_ff, sm_in, inside_ff, inside_in;
   logic signed [EW-1:0] ex_ff, ex_in, ey_ff, ey_in, wx_ff, wx_in, wy_ff, wy_in;
   logic signed [PW-1:0] p1_ff, p1_in, p2_ff, p2_in, p3_ff, p3_in, p4_ff, p4_in;
   logic signed [PW-1:0] p5_ff, p5_in, p6_ff, p6_in, p7_ff, p7_in, p8_ff, p8_in;
   logic [EEW-1:0] ee_ff, ee_in;
   logic [EEW-1:0] rem_ff, rem_in;
   logic [HW-1:0] h_ff, h_in;
   logic [3:0] cnt_ff, cnt_in;
   logic signed [BW-1:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [QW-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [QW-1:0] best_ff, best_in;
   logic sqs_ff, sqs_in;
   logic rv_ff, rv_in, rin_ff, rin_in;
   logic signed [DIST_BITS-1:0] rd_ff, rd_in;

   logic signed [DW-1:0] dsum;
   logic [EEW-1:0] esum;
   logic [QW-1:0] w2, sq;
   logic [EEW:0] trial;
   logic signed [PW-1:0] rx, ry;
   logic c0, c1, c2;
   logic [CNT_BITS-1:0] vc;

   always_comb begin
      state_in = state_ff;
      px_in = px_ff; py_in = py_ff;
      prevx_in = prevx_ff; prevy_in = prevy_ff;
      curx_in = curx_ff; cury_in = cury_ff;
      last_in = last_ff; idx_in = idx_ff;
      sm_in = sm_ff; inside_in = inside_ff;
      ex_in = ex_ff; ey_in = ey_ff; wx_in = wx_ff; wy_in = wy_ff;
      p1_in = p1_ff; p2_in = p2_ff; p3_in = p3_ff; p4_in = p4_ff;
      p5_in = p5_ff; p6_in = p6_ff; p7_in = p7_ff; p8_in = p8_ff;
      ee_in = ee_ff; rem_in = rem_ff; h_in = h_ff; cnt_in = cnt_ff;
      bx_in = bx_ff; by_in = by_ff; qx_in = qx_ff; qy_in = qy_ff;
      best_in = best_ff;
      sqs_in = 1'b0;
      rv_in = 1'b0; rin_in = rin_ff; rd_in = rd_ff;
      wr_en = 1'b0;
      rd_addr = idx_ff;

      dsum = DW'(p1_ff) + DW'(p2_ff);
      esum = EEW'(p3_ff) + EEW'(p4_ff);
      w2 = QW'(p7_ff) + QW'(p8_ff);
      sq = QW'(qx_ff) + QW'(qy_ff);
      trial = {rem_ff, 1'b0};
      rx = p1_ff + PW'(32768);
      ry = p2_ff + PW'(32768);
      c0 = py_ff >= cury_ff;
      c1 = py_ff < prevy_ff;
      c2 = p5_ff > p6_ff;
      vc = cfg.vertex_count;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (opcode == OP_WRITE) begin
                  wr_en = 1'b1;
               end else begin
                  px_in = x_coord;
                  py_in = y_coord;
                  sm_in = cfg.signed_mode;
                  inside_in = 1'b0;
                  idx_in = '0;
                  if (vc == '0) begin
                     last_in = '0;
                  end else if (vc > CNT_BITS'(MAX_VERTICES)) begin
                     last_in = VTX_AW'(MAX_VERTICES - 1);
                  end else begin
                     last_in = VTX_AW'(vc - 1'b1);
                  end
                  state_in = ST_RDLAST;
               end
            end
         end
         ST_RDLAST: begin
            rd_addr = last_ff;
            state_in = ST_LDLAST;
         end
         ST_LDLAST: begin
            rd_addr = '0;
            prevx_in = rd_data.x;
            prevy_in = rd_data.y;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            curx_in = rd_data.x;
            cury_in = rd_data.y;
            ex_in = EW'(prevx_ff) - EW'(rd_data.x);
            ey_in = EW'(prevy_ff) - EW'(rd_data.y);
            wx_in = EW'(px_ff) - EW'(rd_data.x);
            wy_in = EW'(py_ff) - EW'(rd_data.y);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            p1_in = wx_ff * ex_ff;
            p2_in = wy_ff * ey_ff;
            p3_in = ex_ff * ex_ff;
            p4_in = ey_ff * ey_ff;
            p5_in = ex_ff * wy_ff;
            p6_in = ey_ff * wx_ff;
            p7_in = wx_ff * wx_ff;
            p8_in = wy_ff * wy_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            ee_in = esum;
            if (idx_ff == '0) begin
               best_in = w2;
            end
            if ((c0 && c1 && c2) || (!c0 && !c1 && !c2)) begin
               inside_in = !inside_ff;
            end
            if (esum == '0 || dsum <= 0) begin
               bx_in = BW'(wx_ff);
               by_in = BW'(wy_ff);
               state_in = ST_SQ;
            end else if (dsum >= $signed({1'b0, esum})) begin
               bx_in = BW'(wx_ff) - BW'(ex_ff);
               by_in = BW'(wy_ff) - BW'(ey_ff);
               state_in = ST_SQ;
            end else begin
               rem_in = dsum[EEW-1:0];
               cnt_in = '0;
               h_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (trial >= {1'b0, ee_ff}) begin
               rem_in = EEW'(trial - {1'b0, ee_ff});
               h_in = {h_ff[HW-2:0], 1'b1};
            end else begin
               rem_in = trial[EEW-1:0];
               h_in = {h_ff[HW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(HW - 1)) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            p1_in = ex_ff * $signed({1'b0, h_ff});
            p2_in = ey_ff * $signed({1'b0, h_ff});
            state_in = ST_BSUB;
         end
         ST_BSUB: begin
            bx_in = BW'(wx_ff) - BW'($signed(rx[PW-1:HW]));
            by_in = BW'(wy_ff) - BW'($signed(ry[PW-1:HW]));
            state_in = ST_SQ;
         end
         ST_SQ: begin
            qx_in = bx_ff * bx_ff;
            qy_in = by_ff * by_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            rd_addr = idx_ff + 1'b1;
            if (sq < best_ff) begin
               best_in = sq;
            end
            prevx_in = curx_ff;
            prevy_in = cury_ff;
            if (idx_ff == last_ff) begin
               sqs_in = 1'b1;
               state_in = ST_ROOT;
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               rv_in = 1'b1;
               rin_in = inside_ff;
               if (sm_ff && inside_ff) begin
                  rd_in = -$signed({1'b0, sqrt_mag});
               end else begin
                  rd_in = $signed({1'b0, sqrt_mag});
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sqs_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sqs_ff <= sqs_in;
         rv_ff <= rv_in;
      end
      px_ff <= px_in; py_ff <= py_in;
      prevx_ff <= prevx_in; prevy_ff <= prevy_in;
      curx_ff <= curx_in; cury_ff <= cury_in;
      last_ff <= last_in; idx_ff <= idx_in;
      sm_ff <= sm_in; inside_ff <= inside_in;
      ex_ff <= ex_in; ey_ff <= ey_in; wx_ff <= wx_in; wy_ff <= wy_in;
      p1_ff <= p1_in; p2_ff <= p2_in; p3_ff <= p3_in; p4_ff <= p4_in;
      p5_ff <= p5_in; p6_ff <= p6_in; p7_ff <= p7_in; p8_ff <= p8_in;
      ee_ff <= ee_in; rem_ff <= rem_in; h_ff <= h_in; cnt_ff <= cnt_in;
      bx_ff <= bx_in; by_ff <= by_in; qx_ff <= qx_in; qy_ff <= qy_in;
      best_ff <= best_in;
      rin_ff <= rin_in; rd_ff <= rd_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign wr_addr = vertex_index;
   assign wr_data.x = x_coord;
   assign wr_data.y = y_coord;
   assign sqrt_start = sqs_ff;
   assign sqrt_value = best_ff[SQ_BITS-1:0];
   assign rsp_valid = rv_ff;
   assign rsp_distance = rd_ff;
   assign rsp_inside_res = rin_ff;
endmodule

>>> src/polygon_signed_distance_top.sv
// Top level of the polygon signed distance block.
//
//   channel   handshake                ports
//   request   start high, busy low     req_opcode, req_vertex_index, req_x_coord, req_y_coord
//   response  rsp_valid for one cycle  rsp_distance, rsp_inside_res
//   config    psel, penable, pwrite    paddr, pwdata, prdata, pready
//
// A vertex write goes straight into the table. A query first reads the closing
// vertex, then walks every edge, using the 16-step divider for an edge whose
// projection falls inside the segment, and ends in the bit-serial square root unit.
// Reset is synchronous; the vertex table is not cleared. The response is a
// one-cycle beat that the receiver cannot stall.
module polygon_signed_distance_top import psd_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [VTX_AW-1:0]            req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_x_coord,
   input  logic signed [COORD_BITS-1:0] req_y_coord,
   output logic                         rsp_valid,
   output logic signed [DIST_BITS-1:0]  rsp_distance,
   output logic                         rsp_inside_res,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   cfg_type              cfg;
   logic                 wr_en;
   logic [VTX_AW-1:0]    wr_addr;
   vertex_type           wr_data;
   logic [VTX_AW-1:0]    rd_addr;
   vertex_type           rd_data;
   logic                 sqrt_start;
   logic [SQ_BITS-1:0]   sqrt_value;
   logic                 sqrt_done;
   logic [DIST_BITS-2:0] sqrt_mag;

   psd_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   psd_vertex_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   psd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .value(sqrt_value),
      .done(sqrt_done), .mag(sqrt_mag)
   );

   psd_edge_engine u_engine (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .opcode(req_opcode), .vertex_index(req_vertex_index),
      .x_coord(req_x_coord), .y_coord(req_y_coord), .cfg(cfg),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data),
      .sqrt_start(sqrt_start), .sqrt_value(sqrt_value),
      .sqrt_done(sqrt_done), .sqrt_mag(sqrt_mag),
      .rsp_valid(rsp_valid), .rsp_distance(rsp_distance),
      .rsp_inside_res(rsp_inside_res)
   );
endmodule
